>>> rtl/scr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command receiver package
// Shared types, character codes, frame layout constants and helper functions.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Default frame length in bytes, command byte included.
  localparam int FRAME_LEN_DEF = 11;

  // Width of the frame and handshake position counter.
  localparam int CNT_W = 4;

  // Frame layout: groups start at bytes 0, 3 and 6; two check bytes follow.
  localparam int GRP1_IDX   = 3;
  localparam int GRP2_IDX   = 6;
  localparam int PAR_LO_IDX = 9;
  localparam int PAR_HI_IDX = 10;

  // Store walk counter must also hold one past the last check byte.
  localparam int WALK_W = $clog2(PAR_HI_IDX + 2);

  // Character codes on the link.
  localparam logic [7:0] CH_S_UP = 8'h53;
  localparam logic [7:0] CH_R_LO = 8'h72;
  localparam logic [7:0] CH_T_LO = 8'h74;
  localparam logic [7:0] CH_N_UP = 8'h4E;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_E_UP = 8'h45;
  localparam logic [7:0] CH_K_UP = 8'h4B;
  localparam logic [7:0] CH_D_UP = 8'h44;
  localparam logic [7:0] CH_L_UP = 8'h4C;

  // Watchdog enable codes.
  localparam logic [1:0] WD_NONE  = 2'd0;
  localparam logic [1:0] WD_START = 2'd1;
  localparam logic [1:0] WD_STOP  = 2'd2;

  // Operating mode codes.
  localparam logic MODE_IDLE  = 1'b0;
  localparam logic MODE_FAULT = 1'b1;

  // Index of the last letter of the connect reply.
  localparam logic [1:0] DALE_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_THROTTLE,
    PH_FRAME,
    PH_CONNECT
  } phase_t;

  typedef enum logic [1:0] {
    CTL_READY,
    CTL_WALK,
    CTL_CHECK
  } ctl_state_t;

  typedef enum logic [1:0] {
    TX_NONE,
    TX_ACK,
    TX_DALE
  } tx_kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic step;        // a request is accepted this cycle
    logic walk_run;    // read the frame store for the parity check
    logic check_emit;  // load the parity check result into the output register
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic frame_end;   // the offered byte closes a frame
    logic walk_done;   // last check byte has been read from the store
    logic out_free;    // output register can take a new result
  } ctl_sts_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  function automatic logic [7:0] dale_letter(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_D_UP;
      2'd1:    c = CH_A_UP;
      2'd2:    c = CH_L_UP;
      default: c = CH_E_UP;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/scr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command receiver channels
// Valid/ready interfaces for link requests and for result items.
// ----------------------------------------------------------------------------
interface scr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface scr_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;
  logic       link_up;
  logic       startup_request;
  logic       shutdown_request;
  logic       throttle_valid;
  logic [7:0] throttle_value;
  logic       watchdog_reload;
  logic [1:0] watchdog_enable;
  logic       mode_valid;
  logic       mode_code;

  modport source (
    output valid, output tx_valid, output tx_byte, output last, output link_up,
    output startup_request, output shutdown_request, output throttle_valid,
    output throttle_value, output watchdog_reload, output watchdog_enable,
    output mode_valid, output mode_code, input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input last, input link_up,
    input startup_request, input shutdown_request, input throttle_valid,
    input throttle_value, input watchdog_reload, input watchdog_enable,
    input mode_valid, input mode_code, output ready
  );
endinterface

>>> rtl/scr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

>>> rtl/scr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command receiver controller
// Sequences request acceptance, the frame store walk and the check result.
// ----------------------------------------------------------------------------
module scr_ctrl
  import scr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_READY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CTL_READY: begin
        if (in_valid && in_ready && sts.frame_end) begin
          state_nxt = CTL_WALK;
        end
      end
      CTL_WALK: begin
        if (sts.walk_done) begin
          state_nxt = CTL_CHECK;
        end
      end
      CTL_CHECK: begin
        state_nxt = CTL_READY;
      end
      default: begin
        state_nxt = CTL_READY;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state_r)
      CTL_READY: begin
        in_ready = sts.out_free;
        cmd.step = in_valid && sts.out_free;
      end
      CTL_WALK: begin
        cmd.walk_run = 1'b1;
      end
      CTL_CHECK: begin
        cmd.check_emit = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Store reads only complete while the walk is in progress.
  a_walk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sts.walk_done |-> state_r == CTL_WALK)
    else $error("walk completion outside the walk state");

  // The check state is entered only right after the walk has finished.
  a_check_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == CTL_CHECK |-> $past(sts.walk_done))
    else $error("parity check without a finished walk");

  // The output register is empty when the check result is loaded.
  a_check_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.check_emit |-> sts.out_free)
    else $error("check result would overwrite a pending result");

endmodule

>>> rtl/scr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command receiver datapath
// Command decode, link state, frame store, parity walk and result register.
// ----------------------------------------------------------------------------
module scr_datapath
  import scr_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_cmd_t   cmd,
  output ctl_sts_t   sts,
  input  logic       in_action,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_last,
  output logic       out_link_up,
  output logic       out_startup_request,
  output logic       out_shutdown_request,
  output logic       out_throttle_valid,
  output logic [7:0] out_throttle_value,
  output logic       out_watchdog_reload,
  output logic [1:0] out_watchdog_enable,
  output logic       out_mode_valid,
  output logic       out_mode_code
);

  localparam int AW = $clog2(FRAME_LEN);

  // Link state.
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_inc;
  logic             link_r, link_nxt;

  // Frame store write side.
  logic             st_we;
  logic [AW-1:0]    st_waddr;
  logic [7:0]       st_rdata;

  // Step result before it reaches the output register.
  tx_kind_t         r_kind;
  logic             r_start, r_shut, r_thv, r_reload, r_modev, r_mode;
  logic [7:0]       r_thval;
  logic [1:0]       r_wden;
  logic             frame_end;

  // Parity walk.
  logic [WALK_W-1:0] walk_addr_r;
  logic [WALK_W-1:0] rd_idx_r;
  logic              rd_vld_r;
  logic [3:0]        g0_r, g1_r, g2_r;
  logic [7:0]        p9_r, p10_r;
  logic [3:0]        rd_ones;
  logic              parity_ok;

  // Result register.
  logic              o_valid_r;
  tx_kind_t          o_kind_r;
  logic [1:0]        o_idx_r;
  logic              o_link_r, o_start_r, o_shut_r, o_thv_r, o_reload_r;
  logic              o_modev_r, o_mode_r;
  logic [7:0]        o_thval_r;
  logic [1:0]        o_wden_r;
  logic              o_first;
  logic              load_step, load_check;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    count_inc = count_r + CNT_W'(1);
    count_nxt = count_r;
    link_nxt  = link_r;
    st_we     = 1'b0;
    st_waddr  = '0;
    r_kind    = TX_NONE;
    r_start   = 1'b0;
    r_shut    = 1'b0;
    r_thv     = 1'b0;
    r_thval   = '0;
    r_reload  = 1'b0;
    r_wden    = WD_NONE;
    r_modev   = 1'b0;
    r_mode    = MODE_IDLE;
    frame_end = 1'b0;

    if (in_action) begin
      link_nxt = 1'b0;
      r_shut   = 1'b1;
      r_wden   = WD_STOP;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == CH_S_UP && link_r) begin
            r_kind = TX_ACK;
          end else if (in_rx_byte == CH_R_LO && link_r) begin
            r_start = 1'b1;
            r_kind  = TX_ACK;
          end else if (in_rx_byte == CH_T_LO && link_r) begin
            phase_nxt = PH_THROTTLE;
          end else if (in_rx_byte == CH_N_UP && link_r) begin
            phase_nxt = PH_FRAME;
            st_we     = 1'b1;
            st_waddr  = '0;
            count_nxt = CNT_W'(1);
            r_reload  = 1'b1;
          end else if (in_rx_byte == CH_A_UP) begin
            phase_nxt = PH_CONNECT;
          end
        end
        PH_THROTTLE: begin
          r_thv     = 1'b1;
          r_thval   = in_rx_byte;
          r_kind    = TX_ACK;
          phase_nxt = PH_IDLE;
        end
        PH_FRAME: begin
          if (count_r < CNT_W'(FRAME_LEN)) begin
            st_we    = 1'b1;
            st_waddr = AW'(count_r);
          end
          count_nxt = count_inc;
          if (count_inc == CNT_W'(FRAME_LEN)) begin
            count_nxt = '0;
            phase_nxt = PH_IDLE;
            frame_end = 1'b1;
          end
        end
        PH_CONNECT: begin
          count_nxt = count_inc;
          if (count_inc == CNT_W'(1) || count_inc == CNT_W'(2)) begin
            if (in_rx_byte != ((count_inc == CNT_W'(1)) ? CH_C_UP : CH_E_UP)) begin
              phase_nxt = PH_IDLE;
              link_nxt  = 1'b0;
              count_nxt = '0;
            end
          end else if (count_inc == CNT_W'(3)) begin
            if (in_rx_byte == CH_S_UP) begin
              link_nxt = 1'b1;
              r_modev  = 1'b1;
              r_mode   = MODE_IDLE;
              r_wden   = WD_START;
              r_kind   = TX_DALE;
            end else begin
              link_nxt = 1'b0;
            end
            phase_nxt = PH_IDLE;
            count_nxt = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      link_r  <= 1'b0;
    end else if (cmd.step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      link_r  <= link_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Frame store and parity walk
  // --------------------------------------------------------------------------
  scr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.step && st_we),
    .wr_addr (st_waddr),
    .wr_data (in_rx_byte),
    .rd_addr (AW'(walk_addr_r)),
    .rd_data (st_rdata)
  );

  assign rd_ones = popcount8(st_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      walk_addr_r <= '0;
    end else if (cmd.step && frame_end) begin
      rd_vld_r    <= 1'b0;
      walk_addr_r <= '0;
    end else if (cmd.walk_run && walk_addr_r <= WALK_W'(PAR_HI_IDX)) begin
      rd_vld_r    <= 1'b1;
      walk_addr_r <= walk_addr_r + WALK_W'(1);
    end else begin
      rd_vld_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && frame_end) begin
      g0_r <= '0;
      g1_r <= '0;
      g2_r <= '0;
    end else if (rd_vld_r) begin
      if (rd_idx_r < WALK_W'(GRP1_IDX)) begin
        g0_r <= g0_r + rd_ones;
      end else if (rd_idx_r < WALK_W'(GRP2_IDX)) begin
        g1_r <= g1_r + rd_ones;
      end else if (rd_idx_r < WALK_W'(PAR_LO_IDX)) begin
        g2_r <= g2_r + rd_ones;
      end else if (rd_idx_r == WALK_W'(PAR_LO_IDX)) begin
        p9_r <= st_rdata;
      end else begin
        p10_r <= st_rdata;
      end
    end
    rd_idx_r <= walk_addr_r;
  end

  assign parity_ok = ({g1_r, g0_r} == p9_r) && ({g2_r, g1_r} == p10_r);

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign load_step  = cmd.step && !frame_end;
  assign load_check = cmd.check_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (load_step || load_check) begin
      o_valid_r <= 1'b1;
    end else if (o_valid_r && out_ready && out_last) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_step) begin
      o_kind_r   <= r_kind;
      o_idx_r    <= '0;
      o_link_r   <= link_nxt;
      o_start_r  <= r_start;
      o_shut_r   <= r_shut;
      o_thv_r    <= r_thv;
      o_thval_r  <= r_thval;
      o_reload_r <= r_reload;
      o_wden_r   <= r_wden;
      o_modev_r  <= r_modev;
      o_mode_r   <= r_mode;
    end else if (load_check) begin
      o_kind_r   <= TX_NONE;
      o_idx_r    <= '0;
      o_link_r   <= link_r;
      o_start_r  <= 1'b0;
      o_shut_r   <= 1'b0;
      o_thv_r    <= 1'b0;
      o_thval_r  <= '0;
      o_reload_r <= 1'b0;
      o_wden_r   <= WD_NONE;
      o_modev_r  <= !parity_ok;
      o_mode_r   <= parity_ok ? MODE_IDLE : MODE_FAULT;
    end else if (o_valid_r && out_ready && !out_last) begin
      o_idx_r    <= o_idx_r + 2'd1;
    end
  end

  // Pulses and one-shot fields travel on the first item of a request only.
  assign o_first = (o_idx_r == '0);

  always_comb begin
    case (o_kind_r)
      TX_ACK:  out_tx_byte = CH_K_UP;
      TX_DALE: out_tx_byte = dale_letter(o_idx_r);
      default: out_tx_byte = '0;
    endcase
  end

  assign out_valid            = o_valid_r;
  assign out_tx_valid         = (o_kind_r == TX_ACK) || (o_kind_r == TX_DALE);
  assign out_last             = (o_kind_r != TX_DALE) || (o_idx_r == DALE_LAST);
  assign out_link_up          = o_link_r;
  assign out_startup_request  = o_first && o_start_r;
  assign out_shutdown_request = o_first && o_shut_r;
  assign out_throttle_valid   = o_first && o_thv_r;
  assign out_throttle_value   = o_first ? o_thval_r : 8'h00;
  assign out_watchdog_reload  = o_first && o_reload_r;
  assign out_watchdog_enable  = o_first ? o_wden_r : WD_NONE;
  assign out_mode_valid       = o_first && o_modev_r;
  assign out_mode_code        = o_first && o_mode_r;

  assign sts.frame_end = frame_end;
  assign sts.walk_done = rd_vld_r && (rd_idx_r == WALK_W'(PAR_HI_IDX));
  assign sts.out_free  = !o_valid_r || (out_ready && out_last);

  // A new result never lands on one that has not been fully delivered.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load_step || load_check) |-> (!o_valid_r || (out_ready && out_last)))
    else $error("result register overwritten while pending");

  // The connect reply is only sent with the link up.
  a_dale_link: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_kind_r == TX_DALE) |-> o_link_r)
    else $error("connect reply with link down");

  // Only the connect reply spans more than one item.
  a_multi_dale: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_idx_r != '0) |-> o_kind_r == TX_DALE)
    else $error("multi-item result that is not the connect reply");

  // The walk never reads past the second check byte.
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> rd_idx_r <= WALK_W'(PAR_HI_IDX))
    else $error("frame store walk out of range");

endmodule

>>> rtl/serial_command_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command receiver
// Decodes link command bytes and watchdog timeouts into responses and pulses.
// ----------------------------------------------------------------------------
// Each request on the input channel is either a received link byte or a
// watchdog timeout tick. It produces one result item, or four for the DALE
// reply that completes the connect handshake. Most requests are decoded in
// the cycle they are accepted, and their result sits in the output register
// from the next cycle. A new request is accepted in the same cycle that the
// last result item of the previous request is taken. With a sink that is
// always ready, a request that gives one item therefore never holds up the
// next request, and the DALE reply holds it until its four items are taken.
// The byte that closes a frame instead starts a walk of the frame store
// through its single registered read port. The walk reads each byte of the
// frame in turn and then collects the last byte from the port, and a compare
// state follows, in which the check result is loaded. The next request is
// taken after that at the earliest, which is the longest any request
// occupies the block. The frame store has no reset; the parity check only
// ever reads bytes written in the same frame.
// ----------------------------------------------------------------------------
module serial_command_receiver
  import scr_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  scr_in_if.sink    in_ch,
  scr_out_if.source out_ch
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // The controller owns acceptance and sequencing of the parity walk.
  scr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the link state, the frame store and the result register.
  scr_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_action            (in_ch.action),
    .in_rx_byte           (in_ch.rx_byte),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_tx_valid         (out_ch.tx_valid),
    .out_tx_byte          (out_ch.tx_byte),
    .out_last             (out_ch.last),
    .out_link_up          (out_ch.link_up),
    .out_startup_request  (out_ch.startup_request),
    .out_shutdown_request (out_ch.shutdown_request),
    .out_throttle_valid   (out_ch.throttle_valid),
    .out_throttle_value   (out_ch.throttle_value),
    .out_watchdog_reload  (out_ch.watchdog_reload),
    .out_watchdog_enable  (out_ch.watchdog_enable),
    .out_mode_valid       (out_ch.mode_valid),
    .out_mode_code        (out_ch.mode_code)
  );

endmodule
